[design/hfs_pkg.sv]
// ----------------------------------------------------------------------------
// Height field store package
// Shared types and constants of the height grid store with triangle lookup.
// ----------------------------------------------------------------------------
package hfs_pkg;

  localparam int unsigned MAX_DIM_DEF = 257;
  localparam int unsigned SIZE_W = 9;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned FRAC_W = 8;
  localparam int unsigned HGT_W = 16;
  localparam int unsigned OUT_W = 24;
  localparam logic [SIZE_W-1:0] GRID_RESET = 9'd257;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRAP,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_CALC,
    ST_SUM,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       clear_step;
    logic       load;
    logic       wrap;
    logic [1:0] rd_sel;
    logic       rd_en;
    logic       cap0;
    logic       cap1;
    logic       calc;
    logic       sum;
    logic       out_load;
  } hfs_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic clear_done;
  } hfs_sts_t;

endpackage

[design/heightfield_store_with_triangle_interp.sv]
// ----------------------------------------------------------------------------
// Height field store with triangle interpolation
// Square height grid with writes, wrapped point reads and plane lookup.
// ----------------------------------------------------------------------------
// Channel  Dir  Contents
// in_      in   tdata: mode, col, row, frac_col, frac_row, height_in
// out_     out  tdata: height_out, lowest, highest, write_error
// cfg_     in   grid_size
// Writes skip the corner reads; reads and queries make three sequential
// corner reads of the single-port grid memory.
// After reset a clearing sweep zeroes the grid.
// A held result stalls input until it is transferred.
module heightfield_store_with_triangle_interp #(
  parameter int unsigned MAX_DIM = hfs_pkg::MAX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mode[1:0], col[11:2], row[21:12], frac_col[29:22], frac_row[37:30],
  // height_in[53:38], zero fill
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // height_out[23:0], lowest[39:24], highest[55:40], write_error[56], fill
  output logic [63:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data
);
  import hfs_pkg::*;

  logic [SIZE_W-1:0] grid_r;
  hfs_cmd_t cmd;
  hfs_sts_t sts;
  logic in_fire;
  logic signed [OUT_W-1:0] hout;
  logic signed [HGT_W-1:0] lo, hi;
  logic err;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) grid_r <= GRID_RESET;
    else if (cfg_valid) grid_r <= cfg_data;
  end

  assign in_fire = in_tvalid && in_tready;

  hfs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .in_mode(mode_t'(in_tdata[1:0])), .out_tready(out_tready),
    .sts(sts), .cmd(cmd), .in_tready(in_tready), .out_tvalid(out_tvalid)
  );

  hfs_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk(clk), .rst_n(rst_n), .grid_size(grid_r),
    .in_mode(mode_t'(in_tdata[1:0])), .in_col(in_tdata[11:2]),
    .in_row(in_tdata[21:12]), .in_fc(in_tdata[29:22]), .in_fr(in_tdata[37:30]),
    .in_hgt(in_tdata[53:38]), .cmd(cmd), .sts(sts),
    .out_height(hout), .out_lowest(lo), .out_highest(hi), .out_err(err)
  );

  assign out_tdata = {7'd0, err, hi, lo, hout};

  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("ready during result");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready) else $error("second item accepted");

endmodule

[design/hfs_ctrl.sv]
// ----------------------------------------------------------------------------
// Height field store controller
// Sequences the clearing sweep, the corner reads and the result transfer.
// ----------------------------------------------------------------------------
module hfs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  hfs_pkg::mode_t    in_mode,
  input  logic              out_tready,
  input  hfs_pkg::hfs_sts_t sts,
  output hfs_pkg::hfs_cmd_t cmd,
  output logic              in_tready,
  output logic              out_tvalid
);
  import hfs_pkg::*;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      mode_r  <= MODE_NONE;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_fire) begin
          cmd.load  = 1'b1;
          mode_nxt  = in_mode;
          state_nxt = ST_WRAP;
        end
      end
      ST_WRAP: begin
        cmd.wrap = 1'b1;
        unique case (mode_r)
          MODE_READ, MODE_QUERY: state_nxt = ST_RD0;
          default:               state_nxt = ST_CALC;
        endcase
      end
      ST_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd0;
        state_nxt  = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd1;
        cmd.cap0   = 1'b1;
        state_nxt  = ST_RD2;
      end
      ST_RD2: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd2;
        cmd.cap1   = 1'b1;
        state_nxt  = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum      = 1'b1;
        cmd.out_load = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[design/hfs_dp.sv]
// ----------------------------------------------------------------------------
// Height field store datapath
// Grid memory, coordinate wrapping, extremes and plane interpolation.
// ----------------------------------------------------------------------------
module hfs_dp #(
  parameter int unsigned MAX_DIM = hfs_pkg::MAX_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [hfs_pkg::SIZE_W-1:0]    grid_size,
  input  hfs_pkg::mode_t                in_mode,
  input  logic [hfs_pkg::COORD_W-1:0]   in_col,
  input  logic [hfs_pkg::COORD_W-1:0]   in_row,
  input  logic [hfs_pkg::FRAC_W-1:0]    in_fc,
  input  logic [hfs_pkg::FRAC_W-1:0]    in_fr,
  input  logic signed [hfs_pkg::HGT_W-1:0] in_hgt,
  input  hfs_pkg::hfs_cmd_t             cmd,
  output hfs_pkg::hfs_sts_t             sts,
  output logic signed [hfs_pkg::OUT_W-1:0] out_height,
  output logic signed [hfs_pkg::HGT_W-1:0] out_lowest,
  output logic signed [hfs_pkg::HGT_W-1:0] out_highest,
  output logic                          out_err
);
  import hfs_pkg::*;

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned NW = $clog2(MAX_DIM + 1);
  localparam int unsigned CW = (NW > COORD_W ? NW : COORD_W) + 1;
  localparam int unsigned SW = CW + 9;

  logic signed [HGT_W-1:0] mem [DEPTH];
  logic signed [HGT_W-1:0] rd_q_r;
  logic [AW-1:0] clr_addr_r;

  mode_t mode_r;
  logic [COORD_W-1:0] col_r, row_r;
  logic [FRAC_W-1:0] fc_r, fr_r;
  logic signed [HGT_W-1:0] hin_r;
  logic [NW-1:0] n_r;
  logic [NW-1:0] x0_r, x1_r, y0_r, y1_r;
  logic upper_r, err_r, wr_ok_r;
  logic signed [HGT_W-1:0] ha_r, hb_r;
  logic signed [HGT_W-1:0] lo_r, hi_r;
  logic signed [OUT_W+1:0] p0_r, p1_r, p2_r;
  logic signed [OUT_W-1:0] hout_r;
  logic [HGT_W-1:0] wmask;

  // Clamped size.
  logic [NW-1:0] n_use;
  always_comb begin
    if (grid_size < 2) n_use = NW'(2);
    else if (32'(grid_size) > MAX_DIM) n_use = NW'(MAX_DIM);
    else n_use = NW'(grid_size);
  end

  // Wrapping is a restoring reduction by shifted copies of the size. The
  // upper four steps run when the item is loaded, the lower five in the
  // wrap cycle, which covers every coordinate below 1024 for sizes of two
  // and up.
  function automatic logic [COORD_W-1:0] reduce_hi(input logic [CW-1:0] v,
                                                    input logic [NW-1:0] n);
    logic [SW-1:0] t;
    logic [SW-1:0] nn;
    t  = SW'(v);
    nn = SW'(n);
    if (t >= (nn << 8)) t = t - (nn << 8);
    if (t >= (nn << 7)) t = t - (nn << 7);
    if (t >= (nn << 6)) t = t - (nn << 6);
    if (t >= (nn << 5)) t = t - (nn << 5);
    reduce_hi = COORD_W'(t);
  endfunction

  function automatic logic [NW-1:0] wrap_val(input logic [CW-1:0] v,
                                             input logic [NW-1:0] n);
    logic [SW-1:0] t;
    logic [SW-1:0] nn;
    t  = SW'(v);
    nn = SW'(n);
    if (t >= (nn << 4)) t = t - (nn << 4);
    if (t >= (nn << 3)) t = t - (nn << 3);
    if (t >= (nn << 2)) t = t - (nn << 2);
    if (t >= (nn << 1)) t = t - (nn << 1);
    if (t >= nn) t = t - nn;
    wrap_val = NW'(t);
  endfunction

  // Column of corner wrapped: col+1 mod n equals wrapped col + 1 mod n.
  logic [NW-1:0] xw, yw, xw1, yw1;
  always_comb begin
    xw  = wrap_val(CW'(col_r), n_r);
    yw  = wrap_val(CW'(row_r), n_r);
    xw1 = (xw == n_r - NW'(1)) ? '0 : xw + NW'(1);
    yw1 = (yw == n_r - NW'(1)) ? '0 : yw + NW'(1);
  end

  // Read address for the selected corner.
  logic [NW-1:0] ax, ay;
  logic [AW-1:0] rd_addr, wr_addr;
  always_comb begin
    ax = x0_r;
    ay = y0_r;
    case (cmd.rd_sel)
      2'd0: begin
        ax = (mode_r == MODE_QUERY) ? x1_r : x0_r;
        ay = y0_r;
      end
      2'd1: begin
        ax = x0_r;
        ay = y1_r;
      end
      default: begin
        ax = (mode_r == MODE_QUERY && upper_r) ? x1_r : x0_r;
        ay = (mode_r == MODE_QUERY && upper_r) ? y1_r : y0_r;
      end
    endcase
    rd_addr = AW'(32'(ax) + 32'(ay) * 32'(n_r));
    wr_addr = AW'(32'(col_r) + 32'(row_r) * 32'(n_r));
  end

  assign wmask = '0;

  always_ff @(posedge clk) begin
    if (cmd.clear_step) mem[clr_addr_r] <= signed'(wmask);
    else if (cmd.wrap && wr_ok_r) mem[wr_addr] <= hin_r;
    if (cmd.rd_en) rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_addr_r <= '0;
    else if (cmd.clear_step && clr_addr_r != AW'(DEPTH - 1))
      clr_addr_r <= clr_addr_r + AW'(1);
  end
  assign sts.clear_done = (clr_addr_r == AW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      col_r   <= reduce_hi(CW'(in_col), n_use);
      row_r   <= reduce_hi(CW'(in_row), n_use);
      fc_r    <= in_fc;
      fr_r    <= in_fr;
      hin_r   <= in_hgt;
      n_r     <= n_use;
      upper_r <= (9'(in_fc) + 9'(in_fr)) >= 9'd256;
      err_r   <= (in_mode == MODE_WRITE) &&
                 (32'(in_col) >= 32'(n_use) || 32'(in_row) >= 32'(n_use));
      wr_ok_r <= (in_mode == MODE_WRITE) &&
                 !(32'(in_col) >= 32'(n_use) || 32'(in_row) >= 32'(n_use));
    end
    if (cmd.wrap) begin
      x0_r <= xw;
      y0_r <= yw;
      x1_r <= xw1;
      y1_r <= yw1;
    end
    if (cmd.cap0) ha_r <= rd_q_r;
    if (cmd.cap1) hb_r <= rd_q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= '0;
      hi_r <= '0;
    end else if (cmd.wrap && wr_ok_r) begin
      if (hin_r < lo_r) lo_r <= hin_r;
      if (hin_r > hi_r) hi_r <= hin_r;
    end
  end

  // ha = h10, hb = h01, rd_q = corner base (h00 or h11).
  logic signed [HGT_W:0] d1, d2;
  logic signed [FRAC_W+1:0] w1, w2;
  always_comb begin
    d1 = (HGT_W+1)'(hb_r) - (HGT_W+1)'(rd_q_r);
    d2 = (HGT_W+1)'(ha_r) - (HGT_W+1)'(rd_q_r);
    if (upper_r) begin
      w1 = (FRAC_W+2)'(10'd256 - 10'(fc_r));
      w2 = (FRAC_W+2)'(10'd256 - 10'(fr_r));
    end else begin
      w1 = (FRAC_W+2)'(fr_r);
      w2 = (FRAC_W+2)'(fc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      p0_r <= (OUT_W+2)'(rd_q_r) <<< FRAC_W;
      p1_r <= (OUT_W+2)'(d1) * (OUT_W+2)'(w1);
      p2_r <= (OUT_W+2)'(d2) * (OUT_W+2)'(w2);
    end
    if (cmd.out_load) begin
      case (mode_r)
        MODE_READ:  hout_r <= OUT_W'(p0_r);
        MODE_QUERY: hout_r <= OUT_W'(p0_r + p1_r + p2_r);
        default:    hout_r <= '0;
      endcase
    end
  end

  assign out_height  = hout_r;
  assign out_lowest  = lo_r;
  assign out_highest = hi_r;
  assign out_err     = err_r;

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Height field store testbench
// Drives writes, wrapped point reads and triangle queries through the input
// stream, predicts every result from a local copy of the grid and compares
// each result transfer field by field. Grid sizes are changed between phases
// while the block is idle, including the clamped extremes.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hfs_pkg::*;

  localparam int unsigned DIM = MAX_DIM_DEF;

  typedef struct packed {
    logic signed [23:0] height_out;
    logic signed [15:0] lowest;
    logic signed [15:0] highest;
    logic               write_error;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;

  heightfield_store_with_triangle_interp dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic signed [15:0] grid_copy [DIM*DIM];
  logic signed [15:0] low_mark, high_mark;
  logic [8:0]         size_reg;
  result_t            expected_results [$];
  int                 errors = 0;
  int                 rx_stall;

  function automatic int unsigned eff_size();
    if (size_reg < 2) return 2;
    if (size_reg > DIM) return DIM;
    return size_reg;
  endfunction

  function automatic int corner(int unsigned x, int unsigned y, int unsigned n);
    int unsigned idx;
    idx = (x % n) + (y % n) * n;
    if (idx >= DIM*DIM) return 0;
    return grid_copy[idx];
  endfunction

  function automatic result_t predict_height(mode_t m, int unsigned c, int unsigned r,
                                             int fc, int fr, logic signed [15:0] h);
    result_t     res;
    int unsigned n;
    int          hv, h00, h10, h01, h11;
    n = eff_size();
    hv = 0;
    res.write_error = 1'b0;
    case (m)
      MODE_WRITE: begin
        if (c >= n || r >= n) begin
          res.write_error = 1'b1;
        end else begin
          grid_copy[c + r*n] = h;
          if (h < low_mark) low_mark = h;
          if (h > high_mark) high_mark = h;
        end
      end
      MODE_READ: hv = corner(c, r, n) * 256;
      MODE_QUERY: begin
        h10 = corner(c+1, r, n);
        h01 = corner(c, r+1, n);
        if (fc + fr < 256) begin
          h00 = corner(c, r, n);
          hv = h00*256 + fc*(h10-h00) + fr*(h01-h00);
        end else begin
          h11 = corner(c+1, r+1, n);
          hv = h11*256 + (256-fc)*(h01-h11) + (256-fr)*(h10-h11);
        end
      end
      default: hv = 0;
    endcase
    res.height_out = hv[23:0];
    res.lowest = low_mark;
    res.highest = high_mark;
    return res;
  endfunction

  // With no gap the next transfer is offered right away; the block is busy
  // after each accepted transfer until its result has been transferred.
  task automatic send_item(mode_t m, int unsigned c, int unsigned r,
                           int fc, int fr, logic signed [15:0] h);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {2'b00, h, fr[7:0], fc[7:0], r[9:0], c[9:0], m};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_height(m, c, r, fc, fr, h));
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic set_grid_size(logic [8:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    size_reg = v;
    cfg_valid <= 1'b0;
  endtask

  // Result checker: the stall is redrawn after every transfer.
  always @(posedge clk) begin
    result_t got, exp_r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[23:0], out_tdata[39:24], out_tdata[55:40], out_tdata[56]};
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: %h", $time, got);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.height_out !== exp_r.height_out) begin
            $display("%0t: height_out expected %0d actual %0d", $time,
                     exp_r.height_out, got.height_out);
            errors++;
          end
          if (got.lowest !== exp_r.lowest) begin
            $display("%0t: lowest expected %0d actual %0d", $time,
                     exp_r.lowest, got.lowest);
            errors++;
          end
          if (got.highest !== exp_r.highest) begin
            $display("%0t: highest expected %0d actual %0d", $time,
                     exp_r.highest, got.highest);
            errors++;
          end
          if (got.write_error !== exp_r.write_error) begin
            $display("%0t: write_error expected %0b actual %0b", $time,
                     exp_r.write_error, got.write_error);
            errors++;
          end
        end
        rx_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      end
      if (rx_stall > 0) begin
        out_tready <= 1'b0;
        rx_stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic logic signed [15:0] rand_height();
    case ($urandom_range(0, 3))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic test_directed();
    int unsigned n;
    n = eff_size();
    send_item(MODE_WRITE, 0, 0, 255, 255, 16'sh7fff);
    send_item(MODE_WRITE, n-1, 0, 0, 0, 16'sh8000);
    send_item(MODE_WRITE, 0, n-1, 0, 0, 16'sh1234);
    send_item(MODE_WRITE, n-1, n-1, 0, 0, -16'sd77);
    send_item(MODE_WRITE, n, 0, 0, 0, 16'sh0001);
    send_item(MODE_WRITE, 0, 1023, 0, 0, 16'sh0001);
    send_item(MODE_WRITE, 1023, 1023, 0, 0, -16'sd1);
    send_item(MODE_READ, 0, 0, 255, 255, 16'shffff);
    send_item(MODE_READ, n, n, 0, 0, 0);
    send_item(MODE_READ, 1023, 1023, 0, 0, 0);
    send_item(MODE_QUERY, n-1, n-1, 0, 0, 0);
    send_item(MODE_QUERY, n-1, n-1, 255, 255, 16'sh5555);
    send_item(MODE_QUERY, 0, 0, 128, 127, 0);
    send_item(MODE_QUERY, 0, 0, 128, 128, 0);
    send_item(MODE_QUERY, 1023, 1023, 255, 0, 0);
    send_item(MODE_QUERY, 1023, 0, 0, 255, 0);
    send_item(MODE_NONE, 5, 5, 170, 85, 16'shaaaa);
    send_item(MODE_NONE, 1023, 1023, 255, 255, 16'sh7fff);
  endtask

  task automatic test_random(int count);
    int unsigned n, c, r;
    int          k;
    mode_t       m;
    n = eff_size();
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 19);
      m = (k < 7) ? MODE_WRITE : (k < 11) ? MODE_READ : (k < 19) ? MODE_QUERY : MODE_NONE;
      if ($urandom_range(0, 9) == 0) begin
        c = $urandom_range(0, 1023);
        r = $urandom_range(0, 1023);
      end else begin
        c = $urandom_range(0, n-1);
        r = $urandom_range(0, n-1);
      end
      send_item(m, c, r, $urandom_range(0, 255), $urandom_range(0, 255), rand_height());
    end
  endtask

  task automatic test_sizes();
    set_grid_size(9'd2);
    test_directed();
    test_random(120);
    set_grid_size(9'd0);
    test_random(60);
    set_grid_size(9'd511);
    test_random(120);
    set_grid_size(9'd3);
    test_random(120);
    set_grid_size(9'd1);
    test_random(40);
    set_grid_size(9'd17);
    test_random(150);
    set_grid_size(9'd256);
    test_random(150);
  endtask

  task automatic test_pause();
    test_random(20);
    drain();
    test_random(20);
  endtask

  initial begin
    for (int i = 0; i < DIM*DIM; i++) grid_copy[i] = '0;
    low_mark = '0;
    high_mark = '0;
    size_reg = GRID_RESET;
    rx_stall = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(200);
    test_pause();
    test_sizes();
    set_grid_size(9'd257);
    test_random(100);
    drain();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      if (expected_results.size() != 0)
        $display("%0t: %0d results never arrived", $time, expected_results.size());
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
